// File: rtl/q2rm_pkg.sv
// Shared widths, types and constants for the quaternion to rotation matrix block.
package q2rm_pkg;

  localparam int unsigned QW       = 16;
  localparam int unsigned PW       = 32;
  localparam int unsigned OUT_FRAC = 14;
  localparam int unsigned RW       = 16;
  localparam int unsigned NW       = 2 * QW + 1;
  localparam int unsigned SW       = NW + 2;
  localparam int unsigned STEPS    = OUT_FRAC + 1;
  localparam int unsigned DW       = NW + STEPS;
  localparam int unsigned LANES    = 9;

  localparam logic [STEPS-1:0] ONE = STEPS'(1) << OUT_FRAC;

  typedef struct packed {
    logic signed [2*QW-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
    logic signed [PW-1:0]   px, py, pz;
  } prod_t;

  typedef struct packed {
    logic [NW-1:0]                   den;
    logic [LANES-1:0][SW-1:0]        num;
    logic signed [PW-1:0]            px, py, pz;
  } sum_t;

  typedef struct packed {
    logic [NW-1:0]    rem;
    logic [STEPS-1:0] low;
    logic [STEPS-1:0] quo;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]    lane;
    logic [NW-1:0]        den;
    logic                 zero;
    logic signed [PW-1:0] px, py, pz;
  } div_t;

endpackage

// File: rtl/q2rm_if.sv
// Valid/ready channel interfaces for quaternion input and matrix output beats.
interface q2rm_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      quat_w, quat_x, quat_y, quat_z;
  logic signed [31:0]      pos_x, pos_y, pos_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface q2rm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_r0c0, rot_r0c1, rot_r0c2;
  logic signed [15:0] rot_r1c0, rot_r1c1, rot_r1c2;
  logic signed [15:0] rot_r2c0, rot_r2c1, rot_r2c2;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, out_pos_x, out_pos_y,
                  out_pos_z, input ready);
  modport sink   (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                  rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, out_pos_x, out_pos_y,
                  out_pos_z, output ready);
endinterface

// File: rtl/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix converter with translation pass-through.
//
// in_i carries one quaternion (Q1.15) and a translation (Q16.16) per beat;
// out_o carries the nine rotation entries (Q2.14, rounded to nearest, ties
// away from zero, clipped to +/-1.0) and the unchanged translation.
// A zero quaternion yields the identity rotation.
// The pipeline has one product stage, one sum stage, a setup stage, 15
// restoring-division stages (one quotient bit each, nine lanes sharing the
// norm as divisor) and the output register.
// Throughput is one beat per cycle. The whole pipeline advances whenever the
// output register is empty or being taken; while the receiver stalls, in_i
// ready drops and every stage holds, so nothing is lost or repeated.
// Reset clears all stage valid bits; the output channel is idle after reset.
module quaternion_to_rotation_matrix_core (
  input  logic clk_i,
  input  logic rst_ni,
  q2rm_in_if.sink    in_i,
  q2rm_out_if.source out_o
);
  import q2rm_pkg::*;

  localparam int unsigned NV = STEPS + 4;

  logic              en;
  logic [NV-1:0]     vld_q;
  prod_t             s1_q, s1_d;
  sum_t              s2_q, s2_d;
  div_t              dv_q [STEPS+1];
  div_t              dv_d [STEPS+1];
  logic [LANES-1:0][RW-1:0] rot_d, rot_q;

  assign en          = !vld_q[NV-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[NV-1];

  always_comb begin
    s1_d.ww = in_i.quat_w * in_i.quat_w;
    s1_d.xx = in_i.quat_x * in_i.quat_x;
    s1_d.yy = in_i.quat_y * in_i.quat_y;
    s1_d.zz = in_i.quat_z * in_i.quat_z;
    s1_d.xy = in_i.quat_x * in_i.quat_y;
    s1_d.zw = in_i.quat_z * in_i.quat_w;
    s1_d.xz = in_i.quat_x * in_i.quat_z;
    s1_d.yw = in_i.quat_y * in_i.quat_w;
    s1_d.yz = in_i.quat_y * in_i.quat_z;
    s1_d.xw = in_i.quat_x * in_i.quat_w;
    s1_d.px = in_i.pos_x;
    s1_d.py = in_i.pos_y;
    s1_d.pz = in_i.pos_z;
  end

  always_comb begin
    logic signed [SW-1:0] nn;
    nn = SW'($unsigned(s1_q.ww)) + SW'($unsigned(s1_q.xx))
       + SW'($unsigned(s1_q.yy)) + SW'($unsigned(s1_q.zz));
    s2_d.den    = nn[NW-1:0];
    s2_d.num[0] = nn - 2 * (SW'(s1_q.yy) + SW'(s1_q.zz));
    s2_d.num[1] = 2 * (SW'(s1_q.xy) + SW'(s1_q.zw));
    s2_d.num[2] = 2 * (SW'(s1_q.xz) - SW'(s1_q.yw));
    s2_d.num[3] = 2 * (SW'(s1_q.xy) - SW'(s1_q.zw));
    s2_d.num[4] = nn - 2 * (SW'(s1_q.xx) + SW'(s1_q.zz));
    s2_d.num[5] = 2 * (SW'(s1_q.yz) + SW'(s1_q.xw));
    s2_d.num[6] = 2 * (SW'(s1_q.xz) + SW'(s1_q.yw));
    s2_d.num[7] = 2 * (SW'(s1_q.yz) - SW'(s1_q.xw));
    s2_d.num[8] = nn - 2 * (SW'(s1_q.xx) + SW'(s1_q.yy));
    s2_d.px = s1_q.px;
    s2_d.py = s1_q.py;
    s2_d.pz = s1_q.pz;
  end

  // dividend = |num| * 2^OUT_FRAC + den/2; top bits seed the remainder
  always_comb begin
    logic [SW-1:0] mag;
    logic [DW-1:0] dvd;
    dv_d[0] = '0;
    for (int l = 0; l < LANES; l++) begin
      mag = s2_q.num[l][SW-1] ? -s2_q.num[l] : s2_q.num[l];
      dvd = DW'({mag[NW-1:0], OUT_FRAC'(0)}) + DW'(s2_q.den >> 1);
      dv_d[0].lane[l].rem = dvd[DW-1:STEPS];
      dv_d[0].lane[l].low = dvd[STEPS-1:0];
      dv_d[0].lane[l].quo = '0;
      dv_d[0].lane[l].neg = s2_q.num[l][SW-1];
    end
    dv_d[0].den  = s2_q.den;
    dv_d[0].zero = (s2_q.den == '0);
    dv_d[0].px   = s2_q.px;
    dv_d[0].py   = s2_q.py;
    dv_d[0].pz   = s2_q.pz;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_comb begin
      logic [NW:0] trial;
      logic        ge;
      dv_d[k+1] = dv_q[k];
      for (int l = 0; l < LANES; l++) begin
        trial = {dv_q[k].lane[l].rem, dv_q[k].lane[l].low[STEPS-1]};
        ge    = trial >= {1'b0, dv_q[k].den};
        dv_d[k+1].lane[l].rem = ge ? NW'(trial - {1'b0, dv_q[k].den}) : trial[NW-1:0];
        dv_d[k+1].lane[l].low = dv_q[k].lane[l].low << 1;
        dv_d[k+1].lane[l].quo = {dv_q[k].lane[l].quo[STEPS-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [STEPS-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = (dv_q[STEPS].lane[l].quo > ONE) ? ONE : dv_q[STEPS].lane[l].quo;
      if (dv_q[STEPS].zero) begin
        rot_d[l] = (l == 0 || l == 4 || l == 8) ? RW'(ONE) : '0;
      end else begin
        rot_d[l] = dv_q[STEPS].lane[l].neg ? -RW'(q) : RW'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      for (int k = 0; k <= STEPS; k++) dv_q[k] <= dv_d[k];
      rot_q           <= rot_d;
      out_o.out_pos_x <= dv_q[STEPS].px;
      out_o.out_pos_y <= dv_q[STEPS].py;
      out_o.out_pos_z <= dv_q[STEPS].pz;
    end
  end

  assign out_o.rot_r0c0 = rot_q[0];
  assign out_o.rot_r0c1 = rot_q[1];
  assign out_o.rot_r0c2 = rot_q[2];
  assign out_o.rot_r1c0 = rot_q[3];
  assign out_o.rot_r1c1 = rot_q[4];
  assign out_o.rot_r1c2 = rot_q[5];
  assign out_o.rot_r2c0 = rot_q[6];
  assign out_o.rot_r2c1 = rot_q[7];
  assign out_o.rot_r2c2 = rot_q[8];

endmodule

// File: rtl/q2rm_chk.sv
// Port-level assertion checker for the quaternion to rotation matrix core.
module q2rm_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] r00_i,
  input logic signed [15:0] r01_i,
  input logic signed [15:0] r11_i,
  input logic signed [15:0] r22_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(r00_i) && $stable(r11_i))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow pipeline advance");

  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> r00_i >= -16384 && r00_i <= 16384 && r11_i >= -16384 &&
                    r11_i <= 16384 && r22_i >= -16384 && r22_i <= 16384)
    else $error("diagonal entry out of range");

  a_offd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> r01_i >= -16384 && r01_i <= 16384)
    else $error("off-diagonal entry out of range");
endmodule

bind quaternion_to_rotation_matrix_core q2rm_chk u_q2rm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .r00_i       (out_o.rot_r0c0),
  .r01_i       (out_o.rot_r0c1),
  .r11_i       (out_o.rot_r1c1),
  .r22_i       (out_o.rot_r2c2)
);

// File: tb/sv/quaternion_to_rotation_matrix_core_test.sv
// Self-checking testbench for the quaternion to rotation matrix core.
module quaternion_to_rotation_matrix_core_test;
  import q2rm_pkg::*;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic signed [31:0] px, py, pz;
  } quat_beat_t;

  typedef struct packed {
    logic signed [8:0][15:0] rot;
    logic signed [31:0]      px, py, pz;
  } mat_beat_t;

  typedef struct {
    quat_beat_t q;
    bit         has_exp;
    mat_beat_t  m;
  } dir_row_t;

  localparam logic signed [15:0] Q_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN = -16'sh8000;
  localparam logic signed [15:0] R_ONE = 16'sd16384;
  localparam int RANDOM_BEATS = 1900;
  localparam int LATENCY = 19;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  q2rm_in_if  in_ch();
  q2rm_out_if out_ch();

  quaternion_to_rotation_matrix_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mat_beat_t matrix_q[$];
  int        errors = 0;
  bit        hold_off = 1'b0;
  bit        stim_done = 1'b0;

  function automatic logic signed [15:0] ratio_q14(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< OUT_FRAC) + (den >>> 1)) / den;
    if (q > (longint'(1) <<< OUT_FRAC)) q = longint'(1) <<< OUT_FRAC;
    return (num < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic mat_beat_t rotation_of(quat_beat_t b);
    mat_beat_t m;
    longint w, x, y, z, n;
    w = b.w; x = b.x; y = b.y; z = b.z;
    n = w*w + x*x + y*y + z*z;
    m.px = b.px; m.py = b.py; m.pz = b.pz;
    if (n == 0) begin
      m.rot = '0;
      m.rot[0] = R_ONE; m.rot[4] = R_ONE; m.rot[8] = R_ONE;
    end else begin
      m.rot[0] = ratio_q14(n - 2*(y*y + z*z), n);
      m.rot[1] = ratio_q14(2*(x*y + z*w), n);
      m.rot[2] = ratio_q14(2*(x*z - y*w), n);
      m.rot[3] = ratio_q14(2*(x*y - z*w), n);
      m.rot[4] = ratio_q14(n - 2*(x*x + z*z), n);
      m.rot[5] = ratio_q14(2*(y*z + x*w), n);
      m.rot[6] = ratio_q14(2*(x*z + y*w), n);
      m.rot[7] = ratio_q14(2*(y*z - x*w), n);
      m.rot[8] = ratio_q14(n - 2*(x*x + y*y), n);
    end
    return m;
  endfunction

  function automatic quat_beat_t quat_of(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [31:0] p);
    quat_beat_t b;
    b.w = w; b.x = x; b.y = y; b.z = z;
    b.px = p; b.py = ~p; b.pz = p ^ 32'h5a5a_a5a5;
    return b;
  endfunction

  function automatic mat_beat_t diag_of(quat_beat_t b, logic signed [15:0] d0,
                                        logic signed [15:0] d1, logic signed [15:0] d2);
    mat_beat_t m;
    m.rot = '0;
    m.rot[0] = d0; m.rot[4] = d1; m.rot[8] = d2;
    m.px = b.px; m.py = b.py; m.pz = b.pz;
    return m;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return 16'($urandom_range(0, 3)) - 16'd1;
      3: return 16'($signed(16'($urandom_range(0, 511))) - 16'sd256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(quat_beat_t b);
    in_ch.valid  <= 1'b1;
    in_ch.quat_w <= b.w; in_ch.quat_x <= b.x;
    in_ch.quat_y <= b.y; in_ch.quat_z <= b.z;
    in_ch.pos_x  <= b.px; in_ch.pos_y <= b.py; in_ch.pos_z <= b.pz;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sender: bursts with random gaps; valid stays high across a burst.
  task automatic gap_maybe(ref int burst);
    int gap;
    if (burst > 0) begin
      burst--;
      return;
    end
    burst = $urandom_range(0, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    quat_beat_t b;
    dir_row_t   r;
    int         burst;
    in_ch.valid <= 1'b0;
    in_ch.quat_w <= '0; in_ch.quat_x <= '0; in_ch.quat_y <= '0; in_ch.quat_z <= '0;
    in_ch.pos_x <= '0; in_ch.pos_y <= '0; in_ch.pos_z <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero quaternion, axis-aligned cases (full scale and unit), then predictor-checked rows
    b = quat_of(0, 0, 0, 0, 32'h8000_0000);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, R_ONE, R_ONE, R_ONE); dir_rows.push_back(r);
    b = quat_of(Q_MAX, 0, 0, 0, 32'h7fff_ffff);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, R_ONE, R_ONE, R_ONE); dir_rows.push_back(r);
    b = quat_of(Q_MIN, 0, 0, 0, 32'hffff_ffff);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, R_ONE, R_ONE, R_ONE); dir_rows.push_back(r);
    b = quat_of(0, Q_MIN, 0, 0, 32'h0000_0000);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, R_ONE, -R_ONE, -R_ONE); dir_rows.push_back(r);
    b = quat_of(0, 0, Q_MAX, 0, 32'h0001_0000);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, -R_ONE, R_ONE, -R_ONE); dir_rows.push_back(r);
    b = quat_of(0, 0, 0, 16'd1, 32'h1234_5678);
    r.q = b; r.has_exp = 1; r.m = diag_of(b, -R_ONE, -R_ONE, R_ONE); dir_rows.push_back(r);
    r.has_exp = 0;
    foreach (dir_rows[i]) ;
    r.q = quat_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'hdead_beef); dir_rows.push_back(r);
    r.q = quat_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'h0bad_f00d); dir_rows.push_back(r);
    r.q = quat_of(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'h5555_5555); dir_rows.push_back(r);
    r.q = quat_of(1, 1, 1, 1, 32'haaaa_aaaa); dir_rows.push_back(r);
    r.q = quat_of(16'hffff, 1, 0, 0, 32'h0000_ffff); dir_rows.push_back(r);
    r.q = quat_of(23170, 23170, 0, 0, 32'hffff_0000); dir_rows.push_back(r);
    r.q = quat_of(0, 23170, 0, 16'(-23170), 32'h1); dir_rows.push_back(r);
    r.q = quat_of(3, 1, 16'hffff, 2, 32'h8000_0001); dir_rows.push_back(r);
    r.q = quat_of(Q_MIN, 1, 0, 0, 32'h7fff_fffe); dir_rows.push_back(r);
    r.q = quat_of(100, 16'(-200), 300, 16'(-400), 32'h3c3c_3c3c); dir_rows.push_back(r);

    foreach (dir_rows[i]) begin
      matrix_q.push_back(dir_rows[i].has_exp ? dir_rows[i].m : rotation_of(dir_rows[i].q));
      send_beat(dir_rows[i].q);
    end
    in_ch.valid <= 1'b0;

    burst = 0;
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k == 400) begin
        in_ch.valid <= 1'b0;
        wait (matrix_q.size() == 0);
        @(posedge clk_i);
      end
      if (k == 800) hold_off <= 1'b1;
      gap_maybe(burst);
      b = quat_of(rand_comp(), rand_comp(), rand_comp(), rand_comp(), $urandom);
      b.py = $urandom; b.pz = $urandom;
      matrix_q.push_back(rotation_of(b));
      send_beat(b);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: stall pattern, plus one long hold-off while the sender keeps going.
  initial begin
    int phase;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      phase++;
      if ((phase / 200) % 2 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ((phase % 7) != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    mat_beat_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.rot[0] = out_ch.rot_r0c0; got.rot[1] = out_ch.rot_r0c1;
      got.rot[2] = out_ch.rot_r0c2; got.rot[3] = out_ch.rot_r1c0;
      got.rot[4] = out_ch.rot_r1c1; got.rot[5] = out_ch.rot_r1c2;
      got.rot[6] = out_ch.rot_r2c0; got.rot[7] = out_ch.rot_r2c1;
      got.rot[8] = out_ch.rot_r2c2;
      got.px = out_ch.out_pos_x; got.py = out_ch.out_pos_y; got.pz = out_ch.out_pos_z;
      if (matrix_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, got);
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.rot[i] !== want.rot[i]) begin
            errors++;
            $display("%0t: rot[%0d] expected %0d actual %0d", $time, i,
                     want.rot[i], got.rot[i]);
          end
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
          errors++;
          $display("%0t: pos expected %h %h %h actual %h %h %h", $time,
                   want.px, want.py, want.pz, got.px, got.py, got.pz);
        end
      end
    end
  end

  initial begin
    wait (stim_done && matrix_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && matrix_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
